@@ rtl/sbsd_pkg.sv @@
`timescale 1ns / 1ps

package sbsd_pkg;

  // input item modes
  localparam logic [1:0] MODE_BYTE = 2'd0;
  localparam logic [1:0] MODE_TICK = 2'd1;
  localparam logic [1:0] MODE_ARM  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TIMEOUT  = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  // header FF FF FD 00: first three bytes in the window, newest lowest
  localparam logic [23:0] HDR_WINDOW = 24'hFFFFFD;
  localparam logic [7:0]  HDR_LAST   = 8'h00;
  localparam logic [1:0]  WIN_FULL   = 2'd3;

  // packet buffer positions
  localparam int unsigned ID_IDX     = 4;
  localparam int unsigned LEN_LO_IDX = 5;
  localparam int unsigned LEN_HI_IDX = 6;
  localparam int unsigned HDR_LEN    = 7;

  // timeout register
  localparam logic [15:0] TIMEOUT_RST = 16'd10;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] rx_byte;
  } sbsd_in_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic [6:0] byte_index;
    logic       last;
    logic [1:0] status;
  } sbsd_out_t;

endpackage

@@ rtl/sbsd_in_reg.sv @@
`timescale 1ns / 1ps

module sbsd_in_reg import sbsd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  sbsd_in_t in_data_i,
  output logic     proc_valid_o,
  output sbsd_in_t proc_data_o,
  input  logic     proc_ready_i
);

  logic     valid_q;
  sbsd_in_t data_q;
  logic     accept;

  // hold the item while the deframer cannot take it
  assign in_stall_o   = valid_q && !proc_ready_i;
  assign accept       = in_valid_i && !in_stall_o;
  assign proc_valid_o = valid_q;
  assign proc_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || proc_ready_i) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= in_data_i;
    end
  end

endmodule

@@ rtl/sbsd_core.sv @@
`timescale 1ns / 1ps

module sbsd_core import sbsd_pkg::*; #(
  parameter int unsigned MAX_PACKET = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] timeout_i,
  input  logic        proc_valid_i,
  input  sbsd_in_t    proc_data_i,
  output logic        proc_ready_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output sbsd_out_t   out_data_o
);

  localparam int unsigned POS_W = $clog2(MAX_PACKET + 1);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_HUNT = 2'd1;
  localparam logic [1:0] PH_HEAD = 2'd2;
  localparam logic [1:0] PH_BODY = 2'd3;

  logic [1:0]       phase_q, phase_d;
  logic [23:0]      win_q, win_d;
  logic [1:0]       fill_q, fill_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       len_lo_q, len_lo_d;
  logic [POS_W-1:0] end_q, end_d;
  logic [15:0]      ticks_q, ticks_d;

  logic             out_valid_q;
  sbsd_out_t        out_q;
  logic             res_valid;
  sbsd_out_t        res;
  logic             go;

  logic [15:0]      limit;
  logic [15:0]      ticks_inc;
  logic [15:0]      full_len;
  logic [16:0]      total;
  logic [POS_W:0]   pos_inc;
  logic [POS_W+6:0] pos_ext;

  // output register frees when empty or taken
  assign proc_ready_o = !out_valid_q || !out_stall_i;
  assign go           = proc_valid_i && proc_ready_o;
  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_q;

  // shared datapath terms
  assign limit     = (timeout_i == 16'd0) ? 16'd1 : timeout_i;
  assign ticks_inc = (ticks_q != 16'hFFFF) ? ticks_q + 16'd1 : ticks_q;
  assign full_len  = {proc_data_i.rx_byte, len_lo_q};
  assign total     = 17'(HDR_LEN) + {1'b0, full_len};
  assign pos_inc   = {1'b0, pos_q} + {{POS_W{1'b0}}, 1'b1};
  assign pos_ext   = {7'd0, pos_q};

  // per-item deframing step
  always_comb begin
    phase_d   = phase_q;
    win_d     = win_q;
    fill_d    = fill_q;
    pos_d     = pos_q;
    len_lo_d  = len_lo_q;
    end_d     = end_q;
    ticks_d   = ticks_q;
    res_valid = 1'b0;
    res       = '0;
    res.byte_value = proc_data_i.rx_byte;
    res.byte_index = pos_ext[6:0];
    res.status     = ST_OK;

    unique case (proc_data_i.mode)
      MODE_ARM: begin
        phase_d  = PH_HUNT;
        win_d    = '0;
        fill_d   = '0;
        pos_d    = '0;
        len_lo_d = '0;
        end_d    = '0;
        ticks_d  = '0;
      end
      MODE_TICK: begin
        if (phase_q != PH_IDLE) begin
          if (ticks_inc >= limit) begin
            phase_d        = PH_IDLE;
            ticks_d        = '0;
            res_valid      = 1'b1;
            res.byte_value = '0;
            res.byte_index = '0;
            res.last       = 1'b1;
            res.status     = ST_TIMEOUT;
          end else begin
            ticks_d = ticks_inc;
          end
        end
      end
      MODE_BYTE: begin
        if (phase_q != PH_IDLE) begin
          ticks_d = '0;
          unique case (phase_q)
            PH_HUNT: begin
              if (fill_q == WIN_FULL && win_q == HDR_WINDOW
                  && proc_data_i.rx_byte == HDR_LAST) begin
                phase_d = PH_HEAD;
                pos_d   = POS_W'(ID_IDX);
              end else begin
                win_d = {win_q[15:0], proc_data_i.rx_byte};
                if (fill_q != WIN_FULL) begin
                  fill_d = fill_q + 2'd1;
                end
              end
            end
            PH_HEAD: begin
              pos_d = pos_inc[POS_W-1:0];
              if (pos_q == POS_W'(LEN_LO_IDX)) begin
                len_lo_d = proc_data_i.rx_byte;
              end
              if (pos_q != POS_W'(LEN_HI_IDX)) begin
                res_valid = 1'b1;
              end else if (total > 17'(MAX_PACKET)) begin
                // length does not fit the packet buffer
                phase_d        = PH_IDLE;
                ticks_d        = '0;
                res_valid      = 1'b1;
                res.byte_value = '0;
                res.byte_index = '0;
                res.last       = 1'b1;
                res.status     = ST_TOO_LONG;
              end else if (full_len == 16'd0) begin
                phase_d   = PH_IDLE;
                res_valid = 1'b1;
                res.last  = 1'b1;
              end else begin
                phase_d   = PH_BODY;
                end_d     = total[POS_W-1:0];
                res_valid = 1'b1;
              end
            end
            PH_BODY: begin
              pos_d     = pos_inc[POS_W-1:0];
              res_valid = 1'b1;
              if (pos_inc >= {1'b0, end_q}) begin
                phase_d  = PH_IDLE;
                res.last = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  // deframer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      win_q    <= '0;
      fill_q   <= '0;
      pos_q    <= '0;
      len_lo_q <= '0;
      end_q    <= '0;
      ticks_q  <= '0;
    end else if (go) begin
      phase_q  <= phase_d;
      win_q    <= win_d;
      fill_q   <= fill_d;
      pos_q    <= pos_d;
      len_lo_q <= len_lo_d;
      end_q    <= end_d;
      ticks_q  <= ticks_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc_ready_o) begin
      out_valid_q <= go && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && res_valid) begin
      out_q <= res;
    end
  end

endmodule

@@ rtl/servo_bus_status_deframer.sv @@
`timescale 1ns / 1ps

// Servo-bus status reply deframer. Takes one item per clock cycle, every
// cycle, while the result side is not stalled: an item passes an input
// register and one short step of deframing logic into a result register.
// Bytes are searched for the header FF FF FD 00 once an arm item has been
// given; the ID, both length bytes and the body bytes then come out one
// result each with their buffer index, the final one with last set. A tick
// item counts idle time and ends reception with a timeout result once the
// configured tick count is reached; a length that does not fit MAX_PACKET
// ends it with a too-long result. The timeout register resets to 10 ticks.
// The user must write it through the config channel only while no item is
// in flight; the block does not enforce this.
module servo_bus_status_deframer import sbsd_pkg::*; #(
  parameter int unsigned MAX_PACKET = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  sbsd_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output sbsd_out_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic [15:0] timeout_q;
  logic        proc_valid;
  sbsd_in_t    proc_data;
  logic        proc_ready;

  // timeout register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      timeout_q <= cfg_data_i;
    end
  end

  sbsd_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .proc_valid_o (proc_valid),
    .proc_data_o  (proc_data),
    .proc_ready_i (proc_ready)
  );

  sbsd_core #(
    .MAX_PACKET (MAX_PACKET)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .timeout_i    (timeout_q),
    .proc_valid_i (proc_valid),
    .proc_data_i  (proc_data),
    .proc_ready_o (proc_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

  // input only backs up behind a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // a new result needs an item in the input register the cycle before
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o)) |-> $past(proc_valid))
    else $error("result appeared without an item");

  // error results always close the packet with cleared fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != ST_OK) |->
      (out_data_o.last && out_data_o.byte_index == 7'd0
       && out_data_o.byte_value == 8'd0))
    else $error("error result not marked last");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import sbsd_pkg::*;

  localparam int unsigned MAX_PACKET = 128;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned SEGMENT_ITEMS = 50;
  // mode value the block does not define, must be ignored
  localparam logic [1:0] MODE_RSVD = 2'd3;

  // frame predictor and store of expected results
  class deframe_scoreboard;
    typedef enum logic [1:0] {RX_IDLE, RX_HUNT, RX_HEAD, RX_BODY} rx_phase_e;

    logic [15:0] timeout_ticks;
    rx_phase_e   phase;
    logic [23:0] window;
    logic [1:0]  fill;
    int unsigned pos;
    logic [15:0] plen;
    logic [15:0] idle_cnt;
    int unsigned max_packet;
    int unsigned mismatches;
    sbsd_out_t   expected_q[$];

    function new(int unsigned mp);
      max_packet    = mp;
      timeout_ticks = TIMEOUT_RST;
      phase         = RX_IDLE;
      window        = '0;
      fill          = '0;
      pos           = 0;
      plen          = '0;
      idle_cnt      = '0;
      mismatches    = 0;
    endfunction

    function void set_timeout(logic [15:0] v);
      timeout_ticks = v;
    endfunction

    function void push_byte(logic [7:0] v, int unsigned idx, logic last);
      sbsd_out_t r;
      r.byte_value = v;
      r.byte_index = idx[6:0];
      r.last       = last;
      r.status     = ST_OK;
      expected_q.push_back(r);
    endfunction

    // reception ends with an error result and the receiver goes idle
    function void push_error(logic [1:0] st);
      sbsd_out_t r;
      phase    = RX_IDLE;
      idle_cnt = '0;
      r        = '0;
      r.last   = 1'b1;
      r.status = st;
      expected_q.push_back(r);
    endfunction

    // work out the results of one accepted input item
    function void note_input(sbsd_in_t it);
      logic [15:0] lim;
      int unsigned idx;
      if (it.mode == MODE_ARM) begin
        phase    = RX_HUNT;
        window   = '0;
        fill     = '0;
        pos      = 0;
        plen     = '0;
        idle_cnt = '0;
        return;
      end
      if (phase == RX_IDLE) return;
      if (it.mode == MODE_TICK) begin
        lim = (timeout_ticks == 16'd0) ? 16'd1 : timeout_ticks;
        if (idle_cnt != 16'hFFFF) idle_cnt++;
        if (idle_cnt >= lim) push_error(ST_TIMEOUT);
        return;
      end
      if (it.mode != MODE_BYTE) return;

      idle_cnt = '0;
      case (phase)
        RX_HUNT: begin
          if (fill == WIN_FULL && window == HDR_WINDOW && it.rx_byte == HDR_LAST) begin
            phase = RX_HEAD;
            pos   = ID_IDX;
          end else begin
            window = {window[15:0], it.rx_byte};
            if (fill != WIN_FULL) fill++;
          end
        end
        RX_HEAD: begin
          idx = pos;
          if (idx == LEN_LO_IDX) plen = {8'h00, it.rx_byte};
          pos = idx + 1;
          if (idx != LEN_HI_IDX) begin
            push_byte(it.rx_byte, idx, 1'b0);
          end else begin
            plen[15:8] = it.rx_byte;
            if (HDR_LEN + plen > max_packet) begin
              push_error(ST_TOO_LONG);
            end else if (plen == 16'd0) begin
              phase = RX_IDLE;
              push_byte(it.rx_byte, idx, 1'b1);
            end else begin
              phase = RX_BODY;
              push_byte(it.rx_byte, idx, 1'b0);
            end
          end
        end
        RX_BODY: begin
          idx = pos;
          pos = idx + 1;
          if (pos >= HDR_LEN + plen) begin
            phase = RX_IDLE;
            push_byte(it.rx_byte, idx, 1'b1);
          end else begin
            push_byte(it.rx_byte, idx, 1'b0);
          end
        end
        default: ;
      endcase
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_result(sbsd_out_t got);
      sbsd_out_t exp;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value %h index %0d last %b status %0d",
                   got.byte_value, got.byte_index, got.last, got.status);
        return;
      end
      exp = expected_q.pop_front();
      if (got.byte_value !== exp.byte_value || got.byte_index !== exp.byte_index ||
          got.last !== exp.last || got.status !== exp.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %h/%0d/%b/%0d got %h/%0d/%b/%0d",
                   exp.byte_value, exp.byte_index, exp.last, exp.status,
                   got.byte_value, got.byte_index, got.last, got.status);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  sbsd_in_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  sbsd_out_t   out_data_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;

  deframe_scoreboard sb;
  int unsigned       idle_pct;
  int unsigned       stall_pct;
  int unsigned       sent_items;
  int unsigned       cycles;
  int unsigned       tick_limit;

  servo_bus_status_deframer #(
    .MAX_PACKET (MAX_PACKET)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // result side: random stall and result checking
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // offer one input item, with random idle cycles ahead of it
  task automatic send_item(logic [1:0] mode, logic [7:0] b);
    sbsd_in_t it;
    it.mode    = mode;
    it.rx_byte = b;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(it);
    sent_items++;
  endtask

  task automatic send_ticks(int unsigned n);
    repeat (n) send_item(MODE_TICK, 8'($urandom_range(255)));
  endtask

  // sometimes a few ticks that stay below the timeout
  task automatic gap_ticks();
    int unsigned n;
    if ($urandom_range(99) < 20) begin
      n = (tick_limit - 1 < 3) ? tick_limit - 1 : 3;
      if (n > 0) send_ticks($urandom_range(n));
    end
  endtask

  task automatic send_header();
    send_item(MODE_BYTE, 8'hFF);
    gap_ticks();
    send_item(MODE_BYTE, 8'hFF);
    gap_ticks();
    send_item(MODE_BYTE, HDR_WINDOW[7:0]);
    gap_ticks();
    send_item(MODE_BYTE, HDR_LAST);
  endtask

  // random modes and bytes, mostly ignored or breaking reception
  task automatic send_noise();
    repeat ($urandom_range(1, 6))
      send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
  endtask

  // one reply frame with random content, sometimes cut short
  task automatic send_frame();
    int unsigned len;
    int unsigned r;
    int          abort_at;
    logic [7:0]  junk;
    send_item(MODE_ARM, 8'($urandom_range(255)));
    // stray bytes ahead of the header, often header-like
    if ($urandom_range(99) < 30) begin
      repeat ($urandom_range(1, 4)) begin
        r = $urandom_range(3);
        junk = (r == 0) ? 8'hFF : (r == 1) ? HDR_WINDOW[7:0] :
               (r == 2) ? HDR_LAST : 8'($urandom_range(255));
        send_item(MODE_BYTE, junk);
        gap_ticks();
      end
    end
    send_header();
    gap_ticks();
    send_item(MODE_BYTE, 8'($urandom_range(255)));
    r = $urandom_range(99);
    if (r < 60)      len = $urandom_range(12);
    else if (r < 72) len = $urandom_range(13, MAX_PACKET - HDR_LEN);
    else if (r < 76) len = MAX_PACKET - HDR_LEN;
    else if (r < 84) len = MAX_PACKET - HDR_LEN + 1;
    else if (r < 92) len = $urandom_range(MAX_PACKET - HDR_LEN + 2, 16'hFFFF);
    else             len = 0;
    gap_ticks();
    send_item(MODE_BYTE, len[7:0]);
    gap_ticks();
    send_item(MODE_BYTE, len[15:8]);
    if (HDR_LEN + len > MAX_PACKET) return;
    abort_at = ($urandom_range(99) < 10) ? int'($urandom_range(len)) : -1;
    for (int i = 0; i < int'(len); i++) begin
      if (i == abort_at) begin
        if ($urandom_range(1) == 0 || tick_limit > 64) begin
          send_item(MODE_ARM, 8'($urandom_range(255)));
          send_item(MODE_BYTE, 8'hFF);
        end else begin
          send_ticks(tick_limit);
        end
        return;
      end
      gap_ticks();
      send_item(MODE_BYTE, 8'($urandom_range(255)));
    end
  endtask

  // wait until every expected result is in and the pipeline has settled
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_timeout(logic [15:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_timeout(v);
    tick_limit = (v == 16'd0) ? 1 : v;
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [15:0] cfg_list [8];
    int unsigned seg_start;

    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    idle_pct    = 0;
    stall_pct   = 0;
    sent_items  = 0;
    cycles      = 0;
    tick_limit  = TIMEOUT_RST;
    sb          = new(MAX_PACKET);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle items, reserved mode, sliding header, zero length
    send_item(MODE_BYTE, 8'hFF);
    send_item(MODE_RSVD, 8'h00);
    send_item(MODE_TICK, 8'h00);
    send_item(MODE_ARM, 8'hFF);
    send_item(MODE_BYTE, 8'hFF);
    send_header();
    send_item(MODE_BYTE, 8'h00);
    send_item(MODE_BYTE, 8'h00);
    send_item(MODE_BYTE, 8'h00);
    // largest length fields, too long
    send_item(MODE_ARM, 8'h00);
    send_header();
    send_item(MODE_BYTE, 8'hFF);
    send_item(MODE_BYTE, 8'hFF);
    send_item(MODE_BYTE, 8'hFF);
    // rearm mid-hunt, then timeout at the reset tick count
    send_item(MODE_ARM, 8'h00);
    send_item(MODE_BYTE, 8'hFF);
    send_item(MODE_ARM, 8'h00);
    send_ticks(TIMEOUT_RST);
    wait_idle();

    cfg_list[0] = 16'd1;
    cfg_list[1] = 16'd0;
    cfg_list[2] = 16'hFFFF;
    cfg_list[3] = 16'd2;
    cfg_list[4] = 16'($urandom_range(3, 30));
    cfg_list[5] = TIMEOUT_RST;
    cfg_list[6] = 16'($urandom_range(1, 16'hFFFF));
    cfg_list[7] = 16'd5;

    // random frames over several timeout settings and idling patterns
    for (int seg = 0; seg < 8; seg++) begin
      write_timeout(cfg_list[seg]);
      case (seg % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 71; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 71; end
        default: begin idle_pct = 13; stall_pct = 13; end
      endcase
      seg_start = sent_items;
      while (sent_items - seg_start < SEGMENT_ITEMS) begin
        if ($urandom_range(99) < 12) send_noise();
        else send_frame();
      end
      wait_idle();
    end

    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
